/* sv/sprm_pkg.sv */
`timescale 1ns / 1ps

package sprm_pkg;

    localparam int MAX_BUFFER_DEF  = 4096;
    localparam int SAMPLE_BITS_DEF = 24;

    // Width and reset value of the buffer length register.
    localparam int LEN_W     = 13;
    localparam int LEN_RESET = 256;
    localparam int LEN_LIMIT = (1 << LEN_W) - 1;

    typedef enum logic {
        MODE_SAMPLE = 1'b0,
        MODE_CLEAR  = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_SQRT,
        BK_DONE
    } t_back_state;

    // Longest buffer the length register can actually select.
    function automatic int f_eff_max(int max_buffer);
        return (max_buffer < LEN_LIMIT) ? max_buffer : LEN_LIMIT;
    endfunction

    function automatic int f_cnt_w(int max_buffer);
        return $clog2(f_eff_max(max_buffer) + 1);
    endfunction

    // Square-sum width is capped at 64 bits; wider sums saturate there.
    function automatic int f_sum_w(int sample_bits, int max_buffer);
        int nat;
        nat = 2 * sample_bits - 2 + f_cnt_w(max_buffer);
        return (nat > 64) ? 64 : nat;
    endfunction

    // Queue word: {clip, hold_r, hold_l, peak_r, peak_l, count, sum_r, sum_l}.
    function automatic int f_ent_w(int sample_bits, int max_buffer);
        return 1 + 4 * sample_bits + f_cnt_w(max_buffer)
               + 2 * f_sum_w(sample_bits, max_buffer);
    endfunction

endpackage

/* sv/sprm_front.sv */
`timescale 1ns / 1ps

module sprm_front #(
    parameter int MAX_BUFFER  = sprm_pkg::MAX_BUFFER_DEF,
    parameter int SAMPLE_BITS = sprm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    input  logic [sprm_pkg::LEN_W-1:0]            i_cfg_buffer_length,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_mode,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample_left,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample_right,
    output logic                                  o_push_valid,
    input  logic                                  i_push_ready,
    output logic [sprm_pkg::f_ent_w(SAMPLE_BITS, MAX_BUFFER)-1:0] o_push_data
);
    import sprm_pkg::*;

    localparam int SB      = SAMPLE_BITS;
    localparam int EFF_MAX = f_eff_max(MAX_BUFFER);
    localparam int CNT_W   = f_cnt_w(MAX_BUFFER);
    localparam int SUM_W   = f_sum_w(SAMPLE_BITS, MAX_BUFFER);
    localparam int ACC_W   = ((SUM_W > 2 * SB) ? SUM_W : 2 * SB) + 1;
    localparam logic [SB-1:0] UNITY = {{(SB-1){1'b0}}, 1'b1} << (SB - 4);

    logic [LEN_W-1:0] r_len;

    logic             r_stg_vld;
    t_mode            r_stg_mode;
    logic [SB-1:0]    r_stg_mag [2];

    logic [CNT_W-1:0] r_count;
    logic [SB-1:0]    r_run  [2];
    logic [SUM_W-1:0] r_sum  [2];
    logic [SB-1:0]    r_hold [2];
    logic             r_clip;

    logic [SB-1:0]    w_in   [2];
    logic [SB-1:0]    w_mag  [2];
    logic [2*SB-1:0]  w_sq   [2];
    logic [ACC_W-1:0] w_acc  [2];
    logic [SUM_W-1:0] n_sum  [2];
    logic [SB-1:0]    n_run  [2];
    logic [SB-1:0]    n_hold [2];
    logic             n_clip;
    logic [CNT_W:0]   n_count;
    logic [LEN_W-1:0] w_len_cap;
    logic [CNT_W-1:0] w_eff;
    logic             w_is_sample;
    logic             w_end;
    logic             w_done;

    assign w_in[0] = i_sample_left;
    assign w_in[1] = i_sample_right;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_mag[k]  = w_in[k][SB-1] ? (~w_in[k]) + {{(SB-1){1'b0}}, 1'b1} : w_in[k];
            w_sq[k]   = r_stg_mag[k] * r_stg_mag[k];
            w_acc[k]  = ACC_W'(r_sum[k]) + ACC_W'(w_sq[k]);
            n_sum[k]  = (w_acc[k] > ACC_W'({SUM_W{1'b1}})) ? {SUM_W{1'b1}}
                                                             : SUM_W'(w_acc[k]);
            n_run[k]  = (r_stg_mag[k] > r_run[k]) ? r_stg_mag[k] : r_run[k];
            n_hold[k] = (n_run[k] > r_hold[k]) ? n_run[k] : r_hold[k];
        end
    end

    // A length of zero acts as one, anything past the limit as the limit.
    always_comb begin
        if (r_len == '0) begin
            w_len_cap = LEN_W'(1);
        end else if (r_len > LEN_W'(EFF_MAX)) begin
            w_len_cap = LEN_W'(EFF_MAX);
        end else begin
            w_len_cap = r_len;
        end
    end

    assign w_eff       = w_len_cap[CNT_W-1:0];
    assign n_count     = {1'b0, r_count} + {{CNT_W{1'b0}}, 1'b1};
    assign w_end       = n_count >= {1'b0, w_eff};
    assign n_clip      = r_clip | (n_run[0] > UNITY) | (n_run[1] > UNITY);
    assign w_is_sample = (r_stg_mode == MODE_SAMPLE);

    assign o_push_valid = r_stg_vld && w_is_sample && w_end;
    assign o_push_data  = {n_clip, n_hold[1], n_hold[0], n_run[1], n_run[0],
                           n_count[CNT_W-1:0], n_sum[1], n_sum[0]};

    // The staged word retires unless it closes a buffer and the queue is full.
    assign w_done  = r_stg_vld && (!w_is_sample || !w_end || i_push_ready);
    assign o_ready = !r_stg_vld || w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= LEN_W'(LEN_RESET);
            r_stg_vld <= 1'b0;
            r_count   <= '0;
            r_clip    <= 1'b0;
            for (int k = 0; k < 2; k++) begin
                r_run[k]  <= '0;
                r_sum[k]  <= '0;
                r_hold[k] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_len <= i_cfg_buffer_length;
            end
            if (o_ready) begin
                r_stg_vld <= i_valid;
            end
            if (w_done) begin
                if (!w_is_sample) begin
                    r_clip <= 1'b0;
                    for (int k = 0; k < 2; k++) begin
                        r_hold[k] <= '0;
                    end
                end else if (!w_end) begin
                    r_count <= n_count[CNT_W-1:0];
                    for (int k = 0; k < 2; k++) begin
                        r_run[k] <= n_run[k];
                        r_sum[k] <= n_sum[k];
                    end
                end else begin
                    r_count <= '0;
                    r_clip  <= n_clip;
                    for (int k = 0; k < 2; k++) begin
                        r_run[k]  <= '0;
                        r_sum[k]  <= '0;
                        r_hold[k] <= n_hold[k];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_stg_mode <= t_mode'(i_mode);
            for (int k = 0; k < 2; k++) begin
                r_stg_mag[k] <= w_mag[k];
            end
        end
    end

endmodule

/* sv/sprm_fifo.sv */
`timescale 1ns / 1ps

module sprm_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);
    import sprm_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

/* sv/sprm_back.sv */
`timescale 1ns / 1ps

module sprm_back #(
    parameter int MAX_BUFFER  = sprm_pkg::MAX_BUFFER_DEF,
    parameter int SAMPLE_BITS = sprm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_pop_valid,
    output logic                   o_pop_ready,
    input  logic [sprm_pkg::f_ent_w(SAMPLE_BITS, MAX_BUFFER)-1:0] i_pop_data,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [SAMPLE_BITS-1:0] o_peak_left,
    output logic [SAMPLE_BITS-1:0] o_peak_right,
    output logic [SAMPLE_BITS-1:0] o_max_peak_left,
    output logic [SAMPLE_BITS-1:0] o_max_peak_right,
    output logic [SAMPLE_BITS-1:0] o_rms_left,
    output logic [SAMPLE_BITS-1:0] o_rms_right,
    output logic                   o_clipped
);
    import sprm_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int CNT_W  = f_cnt_w(MAX_BUFFER);
    localparam int SUM_W  = f_sum_w(SAMPLE_BITS, MAX_BUFFER);
    localparam int SQ_W   = SUM_W + (SUM_W % 2);
    localparam int H      = SQ_W / 2;
    localparam int RW     = H + 2;
    localparam int STEP_W = $clog2(SUM_W);
    localparam int RT_W   = (H > SB) ? H : SB;
    localparam int O_N    = 2 * SUM_W;
    localparam int O_PK   = O_N + CNT_W;
    localparam int O_HD   = O_PK + 2 * SB;
    localparam int O_CL   = O_HD + 2 * SB;

    t_back_state       r_state;
    t_back_state       n_state;
    logic [STEP_W-1:0] r_step;

    logic [SUM_W-1:0]  r_div  [2];
    logic [CNT_W-1:0]  r_rem  [2];
    logic [CNT_W-1:0]  r_n;
    logic [SQ_W-1:0]   r_src  [2];
    logic [RW-1:0]     r_srem [2];
    logic [H-1:0]      r_root [2];
    logic [SB-1:0]     r_pk   [2];
    logic [SB-1:0]     r_hold [2];
    logic              r_clip;

    logic              r_out_vld;
    logic [SB-1:0]     r_o_pk   [2];
    logic [SB-1:0]     r_o_hold [2];
    logic [SB-1:0]     r_o_rms  [2];
    logic              r_o_clip;

    logic [CNT_W:0]    w_dsh  [2];
    logic [CNT_W:0]    w_dsub [2];
    logic              w_dge  [2];
    logic [SUM_W-1:0]  n_div  [2];
    logic [RW+1:0]     w_ssh  [2];
    logic [RW+1:0]     w_trial[2];
    logic [RW+1:0]     w_ssub [2];
    logic              w_sge  [2];
    logic [RT_W-1:0]   w_rms  [2];
    logic              w_load_out;

    always_comb begin
        n_state     = r_state;
        o_pop_ready = 1'b0;
        w_load_out  = 1'b0;
        case (r_state)
            BK_IDLE: begin
                o_pop_ready = 1'b1;
                if (i_pop_valid) begin
                    n_state = BK_DIV;
                end
            end
            BK_DIV: begin
                if (r_step == '0) begin
                    n_state = BK_SQRT;
                end
            end
            BK_SQRT: begin
                if (r_step == '0) begin
                    n_state = BK_DONE;
                end
            end
            BK_DONE: begin
                if (!r_out_vld || i_ready) begin
                    w_load_out = 1'b1;
                    n_state    = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // Restoring divide, one quotient bit per step, and digit-by-digit square root, one bit pair per step.
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_dsh[k]   = {r_rem[k], r_div[k][SUM_W-1]};
            w_dge[k]   = w_dsh[k] >= {1'b0, r_n};
            w_dsub[k]  = w_dsh[k] - {1'b0, r_n};
            n_div[k]   = {r_div[k][SUM_W-2:0], w_dge[k]};
            w_ssh[k]   = {r_srem[k], r_src[k][SQ_W-1 -: 2]};
            w_trial[k] = {2'b00, r_root[k], 2'b01};
            w_sge[k]   = w_ssh[k] >= w_trial[k];
            w_ssub[k]  = w_ssh[k] - w_trial[k];
            w_rms[k]   = RT_W'(r_root[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                if (i_pop_valid) begin
                    r_step    <= STEP_W'(SUM_W - 1);
                    r_n       <= i_pop_data[O_N +: CNT_W];
                    r_clip    <= i_pop_data[O_CL];
                    r_div[0]  <= i_pop_data[0 +: SUM_W];
                    r_div[1]  <= i_pop_data[SUM_W +: SUM_W];
                    r_pk[0]   <= i_pop_data[O_PK +: SB];
                    r_pk[1]   <= i_pop_data[O_PK + SB +: SB];
                    r_hold[0] <= i_pop_data[O_HD +: SB];
                    r_hold[1] <= i_pop_data[O_HD + SB +: SB];
                    for (int k = 0; k < 2; k++) begin
                        r_rem[k] <= '0;
                    end
                end
            end
            BK_DIV: begin
                for (int k = 0; k < 2; k++) begin
                    r_div[k] <= n_div[k];
                    r_rem[k] <= w_dge[k] ? w_dsub[k][CNT_W-1:0] : w_dsh[k][CNT_W-1:0];
                end
                if (r_step == '0) begin
                    r_step <= STEP_W'(H - 1);
                    for (int k = 0; k < 2; k++) begin
                        r_src[k]  <= SQ_W'(n_div[k]);
                        r_srem[k] <= '0;
                        r_root[k] <= '0;
                    end
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
            BK_SQRT: begin
                r_step <= r_step - 1'b1;
                for (int k = 0; k < 2; k++) begin
                    r_src[k]  <= r_src[k] << 2;
                    r_srem[k] <= w_sge[k] ? w_ssub[k][RW-1:0] : w_ssh[k][RW-1:0];
                    r_root[k] <= {r_root[k][H-2:0], w_sge[k]};
                end
            end
            BK_DONE: begin
                if (w_load_out) begin
                    r_o_clip <= r_clip;
                    for (int k = 0; k < 2; k++) begin
                        r_o_pk[k]   <= r_pk[k];
                        r_o_hold[k] <= r_hold[k];
                        r_o_rms[k]  <= w_rms[k][SB-1:0];
                    end
                end
            end
            default: begin
                r_step <= '0;
            end
        endcase
    end

    assign o_valid          = r_out_vld;
    assign o_peak_left      = r_o_pk[0];
    assign o_peak_right     = r_o_pk[1];
    assign o_max_peak_left  = r_o_hold[0];
    assign o_max_peak_right = r_o_hold[1];
    assign o_rms_left       = r_o_rms[0];
    assign o_rms_right      = r_o_rms[1];
    assign o_clipped        = r_o_clip;

endmodule

/* sv/stereo_peak_rms_meter.sv */
`timescale 1ns / 1ps
// Channel   Handshake                    Word
// sample    i_valid / o_ready            i_mode, i_sample_left, i_sample_right
// config    i_cfg_valid / o_cfg_ready    i_cfg_buffer_length
// result    o_valid / i_ready            peaks, max peaks, rms, clipped
//
// The front takes one sample word per cycle while it is not stalled; its
// multiply-accumulate stage retires each word from a staging register.
// A finished buffer goes through a two-entry queue to the back, which takes
// it while idle, divides the square sum bit by bit, takes the square root a
// bit pair at a time and then loads the result, taking no new buffer till done.
// Reset is synchronous and clears all running state; the front stalls only
// when a word that closes a buffer finds the queue full.
module stereo_peak_rms_meter #(
    parameter int MAX_BUFFER  = sprm_pkg::MAX_BUFFER_DEF,
    parameter int SAMPLE_BITS = sprm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sprm_pkg::LEN_W-1:0]    i_cfg_buffer_length,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_mode,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_left,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_right,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [SAMPLE_BITS-1:0]        o_peak_left,
    output logic [SAMPLE_BITS-1:0]        o_peak_right,
    output logic [SAMPLE_BITS-1:0]        o_max_peak_left,
    output logic [SAMPLE_BITS-1:0]        o_max_peak_right,
    output logic [SAMPLE_BITS-1:0]        o_rms_left,
    output logic [SAMPLE_BITS-1:0]        o_rms_right,
    output logic                          o_clipped
);
    import sprm_pkg::*;

    localparam int ENT_W = f_ent_w(SAMPLE_BITS, MAX_BUFFER);

    logic             w_push_valid;
    logic             w_push_ready;
    logic [ENT_W-1:0] w_push_data;
    logic             w_pop_valid;
    logic             w_pop_ready;
    logic [ENT_W-1:0] w_pop_data;

    assign o_cfg_ready = 1'b1;

    sprm_front #(
        .MAX_BUFFER  (MAX_BUFFER),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_buffer_length (i_cfg_buffer_length),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_mode              (i_mode),
        .i_sample_left       (i_sample_left),
        .i_sample_right      (i_sample_right),
        .o_push_valid        (w_push_valid),
        .i_push_ready        (w_push_ready),
        .o_push_data         (w_push_data)
    );

    sprm_fifo #(
        .WIDTH (ENT_W)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_data)
    );

    sprm_back #(
        .MAX_BUFFER  (MAX_BUFFER),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_pop_valid      (w_pop_valid),
        .o_pop_ready      (w_pop_ready),
        .i_pop_data       (w_pop_data),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_peak_left      (o_peak_left),
        .o_peak_right     (o_peak_right),
        .o_max_peak_left  (o_max_peak_left),
        .o_max_peak_right (o_max_peak_right),
        .o_rms_left       (o_rms_left),
        .o_rms_right      (o_rms_right),
        .o_clipped        (o_clipped)
    );

endmodule

/* sv/sprm_checker.sv */
`timescale 1ns / 1ps

module sprm_checker #(
    parameter int SAMPLE_BITS = sprm_pkg::SAMPLE_BITS_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_ready,
    input logic                   o_valid,
    input logic                   i_ready,
    input logic [SAMPLE_BITS-1:0] o_peak_left,
    input logic [SAMPLE_BITS-1:0] o_peak_right,
    input logic [SAMPLE_BITS-1:0] o_max_peak_left,
    input logic [SAMPLE_BITS-1:0] o_max_peak_right,
    input logic [SAMPLE_BITS-1:0] o_rms_left,
    input logic [SAMPLE_BITS-1:0] o_rms_right,
    input logic                   o_clipped
);
    import sprm_pkg::*;

    localparam logic [SAMPLE_BITS-1:0] UNITY =
        {{(SAMPLE_BITS-1){1'b0}}, 1'b1} << (SAMPLE_BITS - 4);

    // A stalled result stays valid; left peaks, right rms and clip flag hold.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_peak_left)
            && $stable(o_rms_right) && $stable(o_max_peak_left) && $stable(o_clipped))
        else $error("result word changed while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("meter not idle after reset");

    // The held maximum always covers the buffer peak it was updated with.
    a_hold_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_max_peak_left >= o_peak_left && o_max_peak_right >= o_peak_right)
        else $error("max peak below buffer peak");

    // The root of a mean square cannot exceed the largest magnitude.
    a_rms_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_rms_left <= o_peak_left && o_rms_right <= o_peak_right)
        else $error("rms above buffer peak");

    a_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_peak_left > UNITY || o_peak_right > UNITY) |-> o_clipped)
        else $error("clip flag missing on a peak above full scale");

endmodule

bind stereo_peak_rms_meter sprm_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_sprm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_peak_left      (o_peak_left),
    .o_peak_right     (o_peak_right),
    .o_max_peak_left  (o_max_peak_left),
    .o_max_peak_right (o_max_peak_right),
    .o_rms_left       (o_rms_left),
    .o_rms_right      (o_rms_right),
    .o_clipped        (o_clipped)
);
